@@ rtl/core/sbps_pkg.sv @@
// sbps_pkg: shared constants, codes, payload structs and helpers of the
// score bucket priority stack. No dependencies; used by all but sbps_ram.
package sbps_pkg;

    // default geometry of the bucket store
    localparam int NUM_BUCKETS  = 64;
    localparam int BUCKET_DEPTH = 64;

    // fixed field widths
    localparam int SCORE_W     = 12;  // widest raw score: 3 * 15 * 63
    localparam int PEN_W       = 6;
    localparam int CFG_ADDR_W  = 2;
    localparam int TOTAL_OUT_W = 13;
    localparam int ESCORE_W    = 6;
    localparam int ACTION_W    = 2;
    localparam int STATUS_W    = 2;
    localparam int IN_DATA_W   = 96;
    localparam int OUT_DATA_W  = 120;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_RESET = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_PUSH  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_POP   = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_DROP  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_MISMATCH = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_OPEN     = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_EXTEND   = 2'd2;

    // penalty reset values
    localparam logic [PEN_W-1:0] PEN_MISMATCH_RST = 6'd3;
    localparam logic [PEN_W-1:0] PEN_OPEN_RST     = 6'd11;
    localparam logic [PEN_W-1:0] PEN_EXTEND_RST   = 6'd4;

    // input item, last declared field (strand) in the lowest bits
    typedef struct packed {
        logic [7:0]  parent_diff_pos;
        logic        is_diff;
        logic [1:0]  edit_kind;
        logic [3:0]  gap_extends;
        logic [3:0]  gap_opens;
        logic [3:0]  mismatches;
        logic [31:0] sa_high;
        logic [31:0] sa_low;
        logic [7:0]  length;
        logic        strand;
    } in_item_t;

    // per-entry info word as held in the info memory
    typedef struct packed {
        logic [7:0] diff_pos;
        logic [1:0] edit_kind;
        logic [3:0] gap_extends;
        logic [3:0] gap_opens;
        logic [3:0] mismatches;
        logic [7:0] length;
        logic       strand;
    } info_t;

    // result item, last declared field in the lowest bits, zero padded to bytes
    typedef struct packed {
        logic [5:0]             pad;
        logic [TOTAL_OUT_W-1:0] total_entries;
        logic [ESCORE_W-1:0]    entry_score;
        logic [7:0]             out_diff_pos;
        logic [1:0]             out_edit_kind;
        logic [3:0]             out_gap_extends;
        logic [3:0]             out_gap_opens;
        logic [3:0]             out_mismatches;
        logic [31:0]            out_sa_high;
        logic [31:0]            out_sa_low;
        logic [7:0]             out_length;
        logic                   out_strand;
    } out_item_t;

    // score reported on the result, saturated at 63
    function automatic logic [ESCORE_W-1:0] sat_score(input logic [SCORE_W-1:0] v);
        logic [ESCORE_W-1:0] r;
        r = (v > SCORE_W'(63)) ? 6'd63 : v[ESCORE_W-1:0];
        return r;
    endfunction

endpackage

@@ rtl/core/sbps_ram.sv @@
// sbps_ram: generic simple dual-port RAM, one write and one registered read
// port. No dependencies.
module sbps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/core/sbps_ctrl.sv @@
// sbps_ctrl: sequencer of the bucket store: fill count and entry memories,
// non-empty flags, best-bucket mark, upward scan and result register.
// Depends on sbps_pkg and sbps_ram.
module sbps_ctrl #(
    parameter int NUM_BUCKETS  = sbps_pkg::NUM_BUCKETS,
    parameter int BUCKET_DEPTH = sbps_pkg::BUCKET_DEPTH
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [sbps_pkg::ACTION_W-1:0]       s_action,
    input  sbps_pkg::in_item_t                  s_item,
    input  logic [sbps_pkg::SCORE_W-1:0]        s_score,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output sbps_pkg::out_item_t                 m_item,
    output logic [sbps_pkg::STATUS_W-1:0]       m_status
);

    localparam int BKT_W   = $clog2(NUM_BUCKETS);
    localparam int BEST_W  = $clog2(NUM_BUCKETS + 1);
    localparam int FILL_W  = $clog2(BUCKET_DEPTH + 1);
    localparam int SLOTS   = NUM_BUCKETS * BUCKET_DEPTH;
    localparam int ADDR_W  = $clog2(SLOTS);
    localparam int TOTAL_W = $clog2(SLOTS + 1);
    localparam int NE_W    = ((2 ** BKT_W) < 8) ? 8 : (2 ** BKT_W);
    localparam int NG      = NE_W / 8;
    localparam int GRP_W   = (NG > 1) ? $clog2(NG) : 1;
    localparam int INFO_W  = $bits(sbps_pkg::info_t);
    localparam int IVAL_W  = 64;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_PUSH = 6'b000010,
        ST_POP  = 6'b000100,
        ST_READ = 6'b001000,
        ST_DONE = 6'b010000,
        ST_SCAN = 6'b100000
    } state_t;

    // control registers
    state_t                          state_reg, state_next;
    logic [BEST_W-1:0]               best_reg, best_next;
    logic [TOTAL_W-1:0]              total_reg, total_next;
    logic [NE_W-1:0]                 ne_reg, ne_next;
    logic                            scan_reg, scan_next;
    logic [GRP_W-1:0]                grp_reg, grp_next;
    logic                            m_valid_reg, m_valid_next;

    // payload registers
    logic [sbps_pkg::SCORE_W-1:0]    score_reg, score_next;
    sbps_pkg::in_item_t              item_reg, item_next;
    logic [BKT_W-1:0]                bkt_reg, bkt_next;
    sbps_pkg::out_item_t             res_reg, res_next;
    logic [sbps_pkg::STATUS_W-1:0]   res_status_reg, res_status_next;
    sbps_pkg::out_item_t             m_item_reg, m_item_next;
    logic [sbps_pkg::STATUS_W-1:0]   m_status_reg, m_status_next;

    // memory side
    logic                            fill_we;
    logic [BKT_W-1:0]                fill_raddr;
    logic [FILL_W-1:0]               fill_wdata;
    logic [FILL_W-1:0]               fill_rdata;
    logic                            store_we;
    logic [ADDR_W-1:0]               slot_base;
    logic [ADDR_W-1:0]               slot;
    logic [FILL_W-1:0]               slot_off;
    logic [IVAL_W-1:0]               ival_rdata;
    logic [INFO_W-1:0]               info_rdata;
    sbps_pkg::info_t                 info_wr;
    sbps_pkg::info_t                 info_rd;

    // derived values
    logic [FILL_W-1:0]               fill_cur;
    logic [FILL_W-1:0]               fill_inc;
    logic [FILL_W-1:0]               fill_dec;
    logic [TOTAL_W-1:0]              total_inc;
    logic [TOTAL_W-1:0]              total_dec;
    logic                            drop;
    logic                            pool_empty;
    logic                            out_free;
    logic [7:0]                      group_bits;
    logic [2:0]                      first_idx;

    // memories: fill count per bucket, entry interval and info per slot
    sbps_ram #(.WIDTH(FILL_W), .DEPTH(NUM_BUCKETS)) u_fill_ram (
        .aclk    (aclk),
        .wr_en   (fill_we),
        .wr_addr (bkt_reg),
        .wr_data (fill_wdata),
        .rd_addr (fill_raddr),
        .rd_data (fill_rdata)
    );

    sbps_ram #(.WIDTH(IVAL_W), .DEPTH(SLOTS)) u_ival_ram (
        .aclk    (aclk),
        .wr_en   (store_we),
        .wr_addr (slot),
        .wr_data ({item_reg.sa_high, item_reg.sa_low}),
        .rd_addr (slot),
        .rd_data (ival_rdata)
    );

    sbps_ram #(.WIDTH(INFO_W), .DEPTH(SLOTS)) u_info_ram (
        .aclk    (aclk),
        .wr_en   (store_we),
        .wr_addr (slot),
        .wr_data (info_wr),
        .rd_addr (slot),
        .rd_data (info_rdata)
    );

    // entry word as stored, diff position inherited unless is_diff
    always_comb begin
        info_wr.strand      = item_reg.strand;
        info_wr.length      = item_reg.length;
        info_wr.mismatches  = item_reg.mismatches;
        info_wr.gap_opens   = item_reg.gap_opens;
        info_wr.gap_extends = item_reg.gap_extends;
        info_wr.edit_kind   = item_reg.edit_kind;
        info_wr.diff_pos    = item_reg.is_diff ? item_reg.length : item_reg.parent_diff_pos;
    end
    assign info_rd = sbps_pkg::info_t'(info_rdata);

    // fill count lookup: a bucket whose flag is clear holds nothing
    assign fill_raddr = (s_action == sbps_pkg::ACT_PUSH) ? s_score[BKT_W-1:0]
                                                         : best_reg[BKT_W-1:0];
    assign fill_cur   = ne_reg[bkt_reg] ? fill_rdata : '0;
    assign fill_inc   = fill_cur + FILL_W'(1);
    assign fill_dec   = fill_cur - FILL_W'(1);
    assign total_inc  = total_reg + TOTAL_W'(1);
    assign total_dec  = total_reg - TOTAL_W'(1);

    // slot address: bucket base plus position within the bucket
    assign slot_base  = ADDR_W'(int'(bkt_reg) * BUCKET_DEPTH);
    assign slot       = slot_base + ADDR_W'(slot_off);

    assign drop       = (score_reg >= sbps_pkg::SCORE_W'(NUM_BUCKETS))
                        || (fill_cur >= FILL_W'(BUCKET_DEPTH));
    assign pool_empty = (total_reg == '0) || (best_reg == BEST_W'(NUM_BUCKETS));
    assign out_free   = !m_valid_reg || m_tready;

    // scan window of eight bucket flags and its lowest set bit
    assign group_bits = ne_reg[{grp_reg, 3'b000} +: 8];
    always_comb begin
        first_idx = '0;
        for (int i = 7; i >= 0; i--) begin
            if (group_bits[i]) begin
                first_idx = 3'(i);
            end
        end
    end

    // sequencer
    always_comb begin
        state_next      = state_reg;
        best_next       = best_reg;
        total_next      = total_reg;
        ne_next         = ne_reg;
        scan_next       = scan_reg;
        grp_next        = grp_reg;
        score_next      = score_reg;
        item_next       = item_reg;
        bkt_next        = bkt_reg;
        res_next        = res_reg;
        res_status_next = res_status_reg;
        m_item_next     = m_item_reg;
        m_status_next   = m_status_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        fill_we         = 1'b0;
        fill_wdata      = fill_inc;
        store_we        = 1'b0;
        slot_off        = fill_cur;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    scan_next       = 1'b0;
                    res_next        = '0;
                    res_status_next = sbps_pkg::STATUS_OK;
                    res_next.total_entries = sbps_pkg::TOTAL_OUT_W'(total_reg);
                    case (s_action)
                        sbps_pkg::ACT_RESET: begin
                            ne_next    = '0;
                            best_next  = BEST_W'(NUM_BUCKETS);
                            total_next = '0;
                            res_next.total_entries = '0;
                            state_next = ST_DONE;
                        end
                        sbps_pkg::ACT_PUSH: begin
                            score_next = s_score;
                            item_next  = s_item;
                            bkt_next   = s_score[BKT_W-1:0];
                            state_next = ST_PUSH;
                        end
                        sbps_pkg::ACT_POP: begin
                            if (pool_empty) begin
                                res_status_next = sbps_pkg::STATUS_EMPTY;
                                state_next      = ST_DONE;
                            end else begin
                                bkt_next   = best_reg[BKT_W-1:0];
                                state_next = ST_POP;
                            end
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            // append to the bucket unless out of range or full
            ST_PUSH: begin
                res_next             = '0;
                res_next.entry_score = sbps_pkg::sat_score(score_reg);
                if (drop) begin
                    res_status_next        = sbps_pkg::STATUS_DROP;
                    res_next.total_entries = sbps_pkg::TOTAL_OUT_W'(total_reg);
                end else begin
                    store_we         = 1'b1;
                    fill_we          = 1'b1;
                    ne_next[bkt_reg] = 1'b1;
                    total_next       = total_inc;
                    if (best_reg > BEST_W'(bkt_reg)) begin
                        best_next = BEST_W'(bkt_reg);
                    end
                    res_status_next        = sbps_pkg::STATUS_OK;
                    res_next.total_entries = sbps_pkg::TOTAL_OUT_W'(total_inc);
                end
                state_next = ST_DONE;
            end

            // take the newest entry of the best bucket
            ST_POP: begin
                slot_off   = fill_dec;
                fill_we    = 1'b1;
                fill_wdata = fill_dec;
                if (fill_dec == '0) begin
                    ne_next[bkt_reg] = 1'b0;
                end
                total_next = total_dec;
                if (total_dec == '0) begin
                    best_next = BEST_W'(NUM_BUCKETS);
                    scan_next = 1'b0;
                end else begin
                    scan_next = (fill_dec == '0);
                end
                grp_next   = GRP_W'(bkt_reg >> 3);
                state_next = ST_READ;
            end

            // entry memories have answered
            ST_READ: begin
                res_next                 = '0;
                res_next.out_strand      = info_rd.strand;
                res_next.out_length      = info_rd.length;
                res_next.out_sa_low      = ival_rdata[31:0];
                res_next.out_sa_high     = ival_rdata[63:32];
                res_next.out_mismatches  = info_rd.mismatches;
                res_next.out_gap_opens   = info_rd.gap_opens;
                res_next.out_gap_extends = info_rd.gap_extends;
                res_next.out_edit_kind   = info_rd.edit_kind;
                res_next.out_diff_pos    = info_rd.diff_pos;
                res_next.entry_score     = sbps_pkg::sat_score(sbps_pkg::SCORE_W'(bkt_reg));
                res_next.total_entries   = sbps_pkg::TOTAL_OUT_W'(total_reg);
                res_status_next          = sbps_pkg::STATUS_OK;
                state_next               = ST_DONE;
            end

            // hand the result to the output register
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_item_next   = res_reg;
                    m_status_next = res_status_reg;
                    state_next    = scan_reg ? ST_SCAN : ST_IDLE;
                end
            end

            // look upward for the next non-empty bucket, eight per cycle
            ST_SCAN: begin
                if (|group_bits) begin
                    best_next  = BEST_W'({grp_reg, first_idx});
                    state_next = ST_IDLE;
                end else if (grp_reg == GRP_W'(NG - 1)) begin
                    best_next  = BEST_W'(NUM_BUCKETS);
                    state_next = ST_IDLE;
                end else begin
                    grp_next = grp_reg + GRP_W'(1);
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            best_reg    <= BEST_W'(NUM_BUCKETS);
            total_reg   <= '0;
            ne_reg      <= '0;
            scan_reg    <= 1'b0;
            grp_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            best_reg    <= best_next;
            total_reg   <= total_next;
            ne_reg      <= ne_next;
            scan_reg    <= scan_next;
            grp_reg     <= grp_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        score_reg      <= score_next;
        item_reg       <= item_next;
        bkt_reg        <= bkt_next;
        res_reg        <= res_next;
        res_status_reg <= res_status_next;
        m_item_reg     <= m_item_next;
        m_status_reg   <= m_status_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_item   = m_item_reg;
    assign m_status = m_status_reg;

endmodule

@@ rtl/core/score_bucket_priority_stack_top.sv @@
// score_bucket_priority_stack_top: stream ports, penalty registers and score
// calculation around the bucket store sequencer. Depends on sbps_pkg, sbps_ctrl.

// Priority store of search entries, one LIFO bucket per penalty score. Items
// are taken one at a time: a reset action, an unused action or a pop on an
// empty store goes straight to the result hand-off, a push reads the fill
// count, then writes entry and count, and a pop reads the fill count, then
// the entry, then hands off the result. A pop that empties its bucket while
// entries remain adds a scan of the non-empty flags for the next best bucket,
// eight buckets per cycle. The next item is taken while a finished result
// waits on the output. Entries live in two memories of NUM_BUCKETS *
// BUCKET_DEPTH words; the flags are flip-flops cleared at once by reset and
// by the reset action, so no clearing pass is needed.
module score_bucket_priority_stack_top #(
    parameter int NUM_BUCKETS  = sbps_pkg::NUM_BUCKETS,
    parameter int BUCKET_DEPTH = sbps_pkg::BUCKET_DEPTH
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration write port
    input  logic                               cfg_wen,
    input  logic [sbps_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [sbps_pkg::PEN_W-1:0]         cfg_wdata,
    // input stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // strand, length, sa_low, sa_high, mismatches, gap_opens, gap_extends,
    // edit_kind, is_diff, parent_diff_pos
    input  logic [sbps_pkg::IN_DATA_W-1:0]     s_tdata,
    // action
    input  logic [sbps_pkg::ACTION_W-1:0]      s_tuser,
    // result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // out_strand, out_length, out_sa_low, out_sa_high, out_mismatches,
    // out_gap_opens, out_gap_extends, out_edit_kind, out_diff_pos,
    // entry_score, total_entries, zero pad
    output logic [sbps_pkg::OUT_DATA_W-1:0]    m_tdata,
    // status
    output logic [sbps_pkg::STATUS_W-1:0]      m_tuser
);

    logic [sbps_pkg::PEN_W-1:0]   mis_pen_reg;
    logic [sbps_pkg::PEN_W-1:0]   open_pen_reg;
    logic [sbps_pkg::PEN_W-1:0]   ext_pen_reg;
    sbps_pkg::in_item_t           s_item;
    logic [sbps_pkg::SCORE_W-1:0] score;
    sbps_pkg::out_item_t          m_item;

    // penalty registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mis_pen_reg  <= sbps_pkg::PEN_MISMATCH_RST;
            open_pen_reg <= sbps_pkg::PEN_OPEN_RST;
            ext_pen_reg  <= sbps_pkg::PEN_EXTEND_RST;
        end else if (cfg_wen) begin
            case (cfg_addr)
                sbps_pkg::REG_MISMATCH: mis_pen_reg  <= cfg_wdata;
                sbps_pkg::REG_OPEN:     open_pen_reg <= cfg_wdata;
                sbps_pkg::REG_EXTEND:   ext_pen_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // weighted score of the incoming entry
    assign s_item = sbps_pkg::in_item_t'(s_tdata);
    assign score  = sbps_pkg::SCORE_W'(s_item.mismatches)  * sbps_pkg::SCORE_W'(mis_pen_reg)
                  + sbps_pkg::SCORE_W'(s_item.gap_opens)   * sbps_pkg::SCORE_W'(open_pen_reg)
                  + sbps_pkg::SCORE_W'(s_item.gap_extends) * sbps_pkg::SCORE_W'(ext_pen_reg);

    sbps_ctrl #(
        .NUM_BUCKETS  (NUM_BUCKETS),
        .BUCKET_DEPTH (BUCKET_DEPTH)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_action (s_tuser),
        .s_item   (s_item),
        .s_score  (score),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_item   (m_item),
        .m_status (m_tuser)
    );

    assign m_tdata = m_item;

endmodule
